/* hw/rtl/i2ctbw_pkg.sv */
// Shared types and constants for the I2C two-byte write master.
package i2ctbw_pkg;

  // Configuration register indexes.
  localparam int unsigned CfgIdxW = 2;
  localparam logic [CfgIdxW-1:0] CFG_ADDRESS_BYTE = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_ACK_TIMEOUT  = 2'd1;

  localparam int unsigned CfgDataW = 12;
  localparam int unsigned TimeoutW = 12;

  localparam logic [7:0]          ADDR_RESET    = 8'h5E;
  localparam logic [TimeoutW-1:0] TIMEOUT_RESET = 12'd2000;

  // Completion codes reported on status.
  localparam logic [1:0] STATUS_OK        = 2'd0;
  localparam logic [1:0] STATUS_ADDR_NACK = 2'd1;
  localparam logic [1:0] STATUS_DATA_NACK = 2'd2;

  // Bus phases of the write sequence.
  typedef enum logic [4:0] {
    PH_IDLE     = 5'd0,
    PH_START_A  = 5'd1,
    PH_START_B  = 5'd2,
    PH_START_C  = 5'd3,
    PH_BIT_LOW  = 5'd4,
    PH_BIT_HIGH = 5'd5,
    PH_ACK_REL  = 5'd6,
    PH_ACK_POLL = 5'd7,
    PH_STOP_A   = 5'd8,
    PH_STOP_B   = 5'd9,
    PH_STOP_C   = 5'd10
  } phase_e;

  // Configuration values seen by the sequencer.
  typedef struct packed {
    logic [7:0]          address_byte;
    logic [TimeoutW-1:0] ack_timeout_limit;
  } cfg_t;

  // One tick's input item.
  typedef struct packed {
    logic       go;
    logic [7:0] level_value;
    logic       sda_sample;
  } tick_in_t;

  // One tick's result item.
  typedef struct packed {
    logic       scl_level;
    logic       sda_level;
    logic       sda_drive;
    logic       busy_res;
    logic       done_res;
    logic [1:0] status;
  } tick_out_t;

endpackage

/* hw/rtl/i2ctbw_cfg.sv */
// Configuration register file for the I2C two-byte write master.
module i2ctbw_cfg
  import i2ctbw_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  output cfg_t                cfg_o
);

  logic [7:0]          address_byte_q;
  logic [TimeoutW-1:0] ack_timeout_q;

  // Writes are always taken.
  assign cfg_ready_o = 1'b1;

  // Register writes; indexes beyond the list are dropped.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      address_byte_q <= ADDR_RESET;
      ack_timeout_q  <= TIMEOUT_RESET;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_ADDRESS_BYTE: address_byte_q <= cfg_data_i[7:0];
        CFG_ACK_TIMEOUT:  ack_timeout_q  <= cfg_data_i[TimeoutW-1:0];
        default: ;
      endcase
    end
  end

  assign cfg_o.address_byte      = address_byte_q;
  assign cfg_o.ack_timeout_limit = ack_timeout_q;

endmodule

/* hw/rtl/i2ctbw_seq.sv */
// Bus phase sequencer: computes one tick's line levels and advances the write sequence.
module i2ctbw_seq
  import i2ctbw_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      step_i,
  input  tick_in_t  tick_i,
  input  cfg_t      cfg_i,
  output tick_out_t tick_o
);

  phase_e              phase_q, phase_d;
  logic [7:0]          shift_q, shift_d;
  logic [7:0]          held_q, held_d;
  logic [2:0]          bit_count_q, bit_count_d;
  logic [TimeoutW-1:0] poll_count_q, poll_count_d;
  logic                second_q, second_d;
  logic [1:0]          result_q, result_d;
  logic [TimeoutW:0]   poll_next;
  logic                cur_bit;

  assign cur_bit   = shift_q[7];
  assign poll_next = {1'b0, poll_count_q} + {{TimeoutW{1'b0}}, 1'b1};

  // Next phase and datapath state.
  always_comb begin
    phase_d      = phase_q;
    shift_d      = shift_q;
    held_d       = held_q;
    bit_count_d  = bit_count_q;
    poll_count_d = poll_count_q;
    second_d     = second_q;
    result_d     = result_q;
    case (phase_q)
      PH_START_A: phase_d = PH_START_B;
      PH_START_B: phase_d = PH_START_C;
      PH_START_C: begin
        bit_count_d = 3'd0;
        phase_d     = PH_BIT_LOW;
      end
      PH_BIT_LOW: phase_d = PH_BIT_HIGH;
      PH_BIT_HIGH: begin
        shift_d     = {shift_q[6:0], 1'b0};
        bit_count_d = bit_count_q + 3'd1;
        phase_d     = (bit_count_d == 3'd0) ? PH_ACK_REL : PH_BIT_LOW;
      end
      PH_ACK_REL: begin
        poll_count_d = '0;
        phase_d      = PH_ACK_POLL;
      end
      PH_ACK_POLL: begin
        if (!tick_i.sda_sample) begin
          if (!second_q) begin
            // Address acknowledged: load the data byte.
            shift_d     = held_q;
            second_d    = 1'b1;
            bit_count_d = 3'd0;
            phase_d     = PH_BIT_LOW;
          end else begin
            result_d = STATUS_OK;
            phase_d  = PH_STOP_A;
          end
        end else if (poll_next > {1'b0, cfg_i.ack_timeout_limit}) begin
          // A NACK that lasts past the timeout limit ends the transaction with an error.
          result_d = second_q ? STATUS_DATA_NACK : STATUS_ADDR_NACK;
          phase_d  = PH_STOP_A;
        end else begin
          poll_count_d = poll_next[TimeoutW-1:0];
        end
      end
      PH_STOP_A: phase_d = PH_STOP_B;
      PH_STOP_B: phase_d = PH_STOP_C;
      PH_STOP_C: phase_d = PH_IDLE;
      default: begin
        phase_d = PH_IDLE;
        if (tick_i.go) begin
          held_d       = tick_i.level_value;
          shift_d      = cfg_i.address_byte;
          bit_count_d  = 3'd0;
          poll_count_d = '0;
          second_d     = 1'b0;
          result_d     = STATUS_OK;
          phase_d      = PH_START_A;
        end
      end
    endcase
  end

  // Line levels and flags for this tick.
  always_comb begin
    logic scl, sdl, drv, busy, done;
    scl  = 1'b1;
    sdl  = 1'b1;
    drv  = 1'b0;
    busy = 1'b1;
    done = 1'b0;
    case (phase_q)
      PH_START_A: drv = 1'b1;
      PH_START_B: begin
        sdl = 1'b0;
        drv = 1'b1;
      end
      PH_START_C, PH_STOP_A: begin
        scl = 1'b0;
        sdl = 1'b0;
        drv = 1'b1;
      end
      PH_BIT_LOW: begin
        scl = 1'b0;
        sdl = cur_bit;
        drv = 1'b1;
      end
      PH_BIT_HIGH: begin
        sdl = cur_bit;
        drv = 1'b1;
      end
      PH_ACK_REL:  scl = 1'b0;
      PH_ACK_POLL: ;
      PH_STOP_B: begin
        sdl = 1'b0;
        drv = 1'b1;
      end
      PH_STOP_C: begin
        drv  = 1'b1;
        done = 1'b1;
      end
      default: busy = tick_i.go;
    endcase
    // A released line reads high through the pull-up.
    tick_o.scl_level = scl;
    tick_o.sda_level = drv ? sdl : 1'b1;
    tick_o.sda_drive = drv;
    tick_o.busy_res  = busy;
    tick_o.done_res  = done;
    tick_o.status    = result_d;
  end

  // Sequencer state advances once per processed tick.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= PH_IDLE;
      shift_q      <= '0;
      held_q       <= '0;
      bit_count_q  <= '0;
      poll_count_q <= '0;
      second_q     <= 1'b0;
      result_q     <= STATUS_OK;
    end else if (step_i) begin
      phase_q      <= phase_d;
      shift_q      <= shift_d;
      held_q       <= held_d;
      bit_count_q  <= bit_count_d;
      poll_count_q <= poll_count_d;
      second_q     <= second_d;
      result_q     <= result_d;
    end
  end

endmodule

/* hw/rtl/i2c_two_byte_write_master.sv */
// Top level of the I2C two-byte write master: input register, sequencer, result register.
//
// Each accepted input item is one bus phase tick and produces exactly one result item
// with the SCL/SDA levels, busy, done and status for that tick. The block takes one
// item per clock cycle when the output side is not stalled. An accepted item is held in
// the input register until it can advance; the sequencer computes its result from it
// combinationally and the result register captures that result, holding it while the
// output side is stalled, and presents it with out_valid_o. A full transaction with immediate
// acknowledges spans 43 ticks from go to the done tick; each ACK wait lasts up to
// ack_timeout_limit + 1 poll ticks. Configuration writes are always ready and must be
// issued only while no transaction is in flight.
module i2c_two_byte_write_master
  import i2ctbw_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  // Input tick channel.
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic                go_i,
  input  logic [7:0]          level_value_i,
  input  logic                sda_sample_i,
  // Result channel.
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic                scl_level_o,
  output logic                sda_level_o,
  output logic                sda_drive_o,
  output logic                busy_res_o,
  output logic                done_res_o,
  output logic [1:0]          status_o,
  // Configuration write channel.
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i
);

  cfg_t      cfg;
  tick_in_t  in_q;
  logic      in_valid_q;
  tick_out_t res_d, res_q;
  logic      out_valid_q;
  logic      advance;
  logic      in_take;

  // A tick moves on when the result register is free or being emptied.
  assign advance    = in_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = in_valid_q && !advance;
  assign in_take    = in_valid_i && !in_stall_o;

  i2ctbw_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  // Input register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_take) begin
      in_valid_q <= 1'b1;
    end else if (advance) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_q.go          <= go_i;
      in_q.level_value <= level_value_i;
      in_q.sda_sample  <= sda_sample_i;
    end
  end

  i2ctbw_seq u_seq (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (advance),
    .tick_i (in_q),
    .cfg_i  (cfg),
    .tick_o (res_d)
  );

  // Result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign scl_level_o = res_q.scl_level;
  assign sda_level_o = res_q.sda_level;
  assign sda_drive_o = res_q.sda_drive;
  assign busy_res_o  = res_q.busy_res;
  assign done_res_o  = res_q.done_res;
  assign status_o    = res_q.status;

endmodule

/* sim/i2c_two_byte_write_master_test.sv */
// Self-checking testbench for the I2C two-byte write master, driven tick by tick.
`timescale 1ns / 100ps

module i2c_two_byte_write_master_test
  import i2ctbw_pkg::*;
;

  localparam int unsigned CYCLE_LIMIT      = 500000;
  localparam int unsigned DRAIN_CYCLES     = 6;
  localparam int unsigned LONG_HOLD_CYCLES = 80;

  // Index that maps to no register; a write there must leave both registers alone.
  localparam logic [CfgIdxW-1:0] CFG_UNUSED_IDX = 2'd3;

  // How the simulated slave answers the ACK waits of one write.
  typedef enum logic [1:0] {
    ACK_PROMPT    = 2'd0,
    ACK_LATE      = 2'd1,
    ACK_ADDR_NACK = 2'd2,
    ACK_DATA_NACK = 2'd3
  } ack_mode_e;

  logic                clk_i         = 1'b0;
  logic                rst_ni        = 1'b0;
  logic                in_valid_i    = 1'b0;
  logic                go_i          = 1'b0;
  logic [7:0]          level_value_i = 8'h00;
  logic                sda_sample_i  = 1'b1;
  logic                out_stall_i   = 1'b0;
  logic                cfg_valid_i   = 1'b0;
  logic [CfgIdxW-1:0]  cfg_index_i   = CFG_ADDRESS_BYTE;
  logic [CfgDataW-1:0] cfg_data_i    = '0;
  logic                in_stall_o;
  logic                out_valid_o;
  logic                scl_level_o;
  logic                sda_level_o;
  logic                sda_drive_o;
  logic                busy_res_o;
  logic                done_res_o;
  logic [1:0]          status_o;
  logic                cfg_ready_o;

  i2c_two_byte_write_master i_dut (.*);

  // Clock: 10 ns period.
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Predicted sequencer state and register copies.
  phase_e              seq_phase;
  logic [7:0]          seq_shift;
  logic [7:0]          seq_data;
  logic [2:0]          seq_bits;
  logic [TimeoutW-1:0] seq_polls;
  logic                seq_second;
  logic [1:0]          seq_code;
  logic [7:0]          cfg_addr;
  logic [TimeoutW-1:0] cfg_limit;

  tick_in_t  pending_ticks[$];
  tick_out_t expected_lines[$];

  int unsigned cycle_count    = 0;
  int unsigned mismatch_count = 0;
  int unsigned phase_ticks    = 0;
  bit          in_fire        = 1'b0;
  bit          idling_on      = 1'b1;
  bit          pressure_on    = 1'b0;

  // Driver and receiver bookkeeping.
  int unsigned send_gap       = 0;
  int unsigned stall_left     = 0;
  int unsigned hold_cycles    = 0;
  bit          long_hold_done = 1'b0;

  function automatic void reset_model();
    cfg_addr   = ADDR_RESET;
    cfg_limit  = TIMEOUT_RESET;
    seq_phase  = PH_IDLE;
    seq_shift  = '0;
    seq_data   = '0;
    seq_bits   = '0;
    seq_polls  = '0;
    seq_second = 1'b0;
    seq_code   = STATUS_OK;
  endfunction

  // Advances the predicted sequencer by one tick and returns the lines it drives.
  function automatic tick_out_t advance_bus_tick(input tick_in_t t);
    tick_out_t   r;
    logic        msb;
    logic [12:0] next_polls;
    r.scl_level = 1'b1;
    r.sda_level = 1'b1;
    r.sda_drive = 1'b0;
    r.busy_res  = 1'b1;
    r.done_res  = 1'b0;
    msb = seq_shift[7];
    case (seq_phase)
      PH_START_A: begin
        r.sda_drive = 1'b1;
        seq_phase = PH_START_B;
      end
      PH_START_B: begin
        r.sda_level = 1'b0;
        r.sda_drive = 1'b1;
        seq_phase = PH_START_C;
      end
      PH_START_C: begin
        r.scl_level = 1'b0;
        r.sda_level = 1'b0;
        r.sda_drive = 1'b1;
        seq_bits = '0;
        seq_phase = PH_BIT_LOW;
      end
      PH_BIT_LOW: begin
        r.scl_level = 1'b0;
        r.sda_level = msb;
        r.sda_drive = 1'b1;
        seq_phase = PH_BIT_HIGH;
      end
      PH_BIT_HIGH: begin
        r.sda_level = msb;
        r.sda_drive = 1'b1;
        seq_shift = seq_shift << 1;
        seq_bits = seq_bits + 3'd1;
        seq_phase = (seq_bits == 3'd0) ? PH_ACK_REL : PH_BIT_LOW;
      end
      PH_ACK_REL: begin
        r.scl_level = 1'b0;
        seq_polls = '0;
        seq_phase = PH_ACK_POLL;
      end
      PH_ACK_POLL: begin
        if (!t.sda_sample) begin
          if (!seq_second) begin
            seq_shift = seq_data;
            seq_second = 1'b1;
            seq_bits = '0;
            seq_phase = PH_BIT_LOW;
          end else begin
            seq_code = STATUS_OK;
            seq_phase = PH_STOP_A;
          end
        end else begin
          next_polls = {1'b0, seq_polls} + 13'd1;
          if (next_polls > {1'b0, cfg_limit}) begin
            seq_code = seq_second ? STATUS_DATA_NACK : STATUS_ADDR_NACK;
            seq_phase = PH_STOP_A;
          end else begin
            seq_polls = next_polls[TimeoutW-1:0];
          end
        end
      end
      PH_STOP_A: begin
        r.scl_level = 1'b0;
        r.sda_level = 1'b0;
        r.sda_drive = 1'b1;
        seq_phase = PH_STOP_B;
      end
      PH_STOP_B: begin
        r.sda_level = 1'b0;
        r.sda_drive = 1'b1;
        seq_phase = PH_STOP_C;
      end
      PH_STOP_C: begin
        r.sda_drive = 1'b1;
        r.done_res = 1'b1;
        seq_phase = PH_IDLE;
      end
      default: begin
        r.busy_res = 1'b0;
        seq_phase = PH_IDLE;
        if (t.go) begin
          seq_data = t.level_value;
          seq_shift = cfg_addr;
          seq_bits = '0;
          seq_polls = '0;
          seq_second = 1'b0;
          seq_code = STATUS_OK;
          r.busy_res = 1'b1;
          seq_phase = PH_START_A;
        end
      end
    endcase
    if (!r.sda_drive) r.sda_level = 1'b1;
    r.status = seq_code;
    return r;
  endfunction

  // Queues one tick and the lines it is predicted to produce.
  task automatic queue_tick(input logic go, input logic [7:0] level, input logic sda);
    tick_in_t t;
    t.go = go;
    t.level_value = level;
    t.sda_sample = sda;
    pending_ticks.push_back(t);
    expected_lines.push_back(advance_bus_tick(t));
    phase_ticks++;
  endtask

  // Queues a whole write transaction from go to the done tick; the sequencer must be idle.
  task automatic queue_write(input logic [7:0] data, input ack_mode_e mode);
    logic sda;
    queue_tick(1'b1, data, 1'($urandom_range(0, 1)));
    while (seq_phase != PH_IDLE) begin
      if (seq_phase == PH_ACK_POLL) begin
        case (mode)
          ACK_PROMPT:    sda = 1'b0;
          ACK_LATE:      sda = ($urandom_range(0, 3) != 0);
          ACK_ADDR_NACK: sda = !seq_second;
          default:       sda = seq_second;
        endcase
      end else begin
        sda = 1'($urandom_range(0, 1));
      end
      // A go while busy must be ignored.
      queue_tick($urandom_range(0, 3) == 0, 8'($urandom_range(0, 255)), sda);
    end
  endtask

  // Random writes with short idle stretches of noise between them.
  task automatic queue_random_writes(input int unsigned tick_count);
    int unsigned pick;
    ack_mode_e   mode;
    phase_ticks = 0;
    while (phase_ticks < tick_count) begin
      repeat ($urandom_range(0, 3)) begin
        queue_tick(1'b0, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
      end
      pick = $urandom_range(0, 9);
      if (pick < 5) mode = ACK_PROMPT;
      else if (pick < 8) mode = ACK_LATE;
      else if (pick == 8) mode = ACK_ADDR_NACK;
      else mode = ACK_DATA_NACK;
      queue_write(8'($urandom_range(0, 255)), mode);
    end
  endtask

  // Brings the sequencer back to idle, then waits until every result has been checked.
  task automatic drain_phase();
    while (seq_phase != PH_IDLE) begin
      queue_tick(1'b0, 8'($urandom_range(0, 255)), 1'b0);
    end
    while (pending_ticks.size() != 0 || expected_lines.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // One register write transaction, mirrored into the predicted registers.
  task automatic write_register(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
    if (idx == CFG_ADDRESS_BYTE) cfg_addr = data[7:0];
    else if (idx == CFG_ACK_TIMEOUT) cfg_limit = data[TimeoutW-1:0];
  endtask

  function automatic void check_field(input string name, input int unsigned want,
                                      input int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, actual %0d", name, want, got);
      mismatch_count++;
    end
  endfunction

  // Input driver: a tick is held until accepted, then the next one is offered.
  always @(negedge clk_i) begin
    bit valid_next;
    if (rst_ni) begin
      if (in_fire) void'(pending_ticks.pop_front());
      if (!in_valid_i || in_fire) begin
        if (send_gap > 0) begin
          send_gap--;
          valid_next = 1'b0;
        end else if (pending_ticks.size() == 0) begin
          valid_next = 1'b0;
        end else if (idling_on && $urandom_range(0, 5) == 0) begin
          send_gap = $urandom_range(0, 4);
          valid_next = 1'b0;
        end else begin
          valid_next = 1'b1;
        end
        in_valid_i <= valid_next;
        if (valid_next) begin
          go_i          <= pending_ticks[0].go;
          level_value_i <= pending_ticks[0].level_value;
          sda_sample_i  <= pending_ticks[0].sda_sample;
        end
      end
    end
  end

  // Result receiver: random stall bursts, and once a long hold-off.
  always @(negedge clk_i) begin
    bit stall_next;
    if (rst_ni) begin
      if (pressure_on && !long_hold_done) begin
        if (hold_cycles < LONG_HOLD_CYCLES) begin
          hold_cycles++;
          stall_next = 1'b1;
        end else begin
          long_hold_done = 1'b1;
          stall_next = 1'b0;
        end
      end else if (stall_left > 0) begin
        stall_left--;
        stall_next = 1'b1;
      end else if (idling_on && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(0, 4);
        stall_next = 1'b1;
      end else begin
        stall_next = 1'b0;
      end
      out_stall_i <= stall_next;
    end
  end

  // Monitor: notes input acceptance and checks each accepted result.
  always @(posedge clk_i) begin
    tick_out_t want;
    cycle_count++;
    in_fire = rst_ni && in_valid_i && !in_stall_o;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_lines.size() == 0) begin
        $error("result with no expectation waiting");
        mismatch_count++;
      end else begin
        want = expected_lines.pop_front();
        check_field("scl_level", want.scl_level, scl_level_o);
        check_field("sda_level", want.sda_level, sda_level_o);
        check_field("sda_drive", want.sda_drive, sda_drive_o);
        check_field("busy_res", want.busy_res, busy_res_o);
        check_field("done_res", want.done_res, done_res_o);
        check_field("status", want.status, status_o);
      end
    end
  end

  // Watchdog on the total run length.
  initial begin
    while (cycle_count < CYCLE_LIMIT) @(posedge clk_i);
    $display("Verification failed");
    $finish;
  end

  // Stimulus sequence, one register setting per phase.
  initial begin
    reset_model();
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Reset settings: idle noise, then clean writes of the extreme data bytes.
    queue_tick(1'b0, 8'hFF, 1'b1);
    queue_tick(1'b0, 8'h00, 1'b0);
    queue_write(8'hFF, ACK_PROMPT);
    queue_write(8'h00, ACK_PROMPT);
    drain_phase();

    // All-ones address, zero timeout: both NACKs, a late-ack write, then random writes.
    write_register(CFG_ADDRESS_BYTE, 12'hFFF);
    write_register(CFG_ACK_TIMEOUT, 12'h000);
    write_register(CFG_UNUSED_IDX, 12'($urandom_range(0, 4095)));
    queue_write(8'($urandom_range(0, 255)), ACK_ADDR_NACK);
    queue_write(8'($urandom_range(0, 255)), ACK_DATA_NACK);
    queue_write(8'($urandom_range(0, 255)), ACK_LATE);
    queue_random_writes(150);
    drain_phase();

    // Zero address, longest timeout: late acknowledges on both bytes.
    write_register(CFG_ADDRESS_BYTE, 12'h000);
    write_register(CFG_ACK_TIMEOUT, 12'hFFF);
    queue_write(8'hA5, ACK_LATE);
    queue_write(8'h5A, ACK_LATE);
    drain_phase();

    // Random address, short timeout, with the receiver holding off once.
    write_register(CFG_ADDRESS_BYTE, 12'($urandom_range(0, 255)));
    write_register(CFG_ACK_TIMEOUT, 12'($urandom_range(1, 6)));
    queue_random_writes(220);
    pressure_on = 1'b1;
    drain_phase();

    // Last part runs with no idling on either side.
    write_register(CFG_ADDRESS_BYTE, 12'($urandom_range(0, 255)));
    write_register(CFG_ACK_TIMEOUT, 12'($urandom_range(0, 15)));
    idling_on = 1'b0;
    queue_random_writes(180);
    drain_phase();

    if (mismatch_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

/* sim.f */
hw/rtl/i2ctbw_pkg.sv
hw/rtl/i2ctbw_cfg.sv
hw/rtl/i2ctbw_seq.sv
hw/rtl/i2c_two_byte_write_master.sv
sim/i2c_two_byte_write_master_test.sv
